// ----- hdl/rsz_pkg.sv -----
// Shared types and constants for the two-pass resize sequencer.
package rsz_pkg;

    localparam int FRAC_BITS_DEF  = 21;
    localparam int ADDR_W         = 32;
    localparam int SIZE_W         = 12;
    localparam int PITCH_W        = 16;
    localparam int PIX_W          = 3;
    localparam int ALPHA_W        = 8;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 32;
    localparam int WORK_PIX_BYTES = 4;

    typedef enum logic [1:0] {
        REQ_START    = 2'd0,
        REQ_COMPLETE = 2'd1,
        REQ_ERROR    = 2'd2
    } req_kind_t;

    typedef enum logic [1:0] {
        KIND_BLEND = 2'd0,
        KIND_BUSY  = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } res_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_START = 4'd0,
        REG_SRC_PITCH = 4'd1,
        REG_SRC_WIDTH = 4'd2,
        REG_SRC_HEIGHT = 4'd3,
        REG_OUT_START = 4'd4,
        REG_OUT_PIX   = 4'd5,
        REG_OUT_WIDTH = 4'd6,
        REG_OUT_HEIGHT = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic                pass;
        logic [ADDR_W-1:0]   bg_addr;
        logic [ADDR_W-1:0]   fg_addr;
        logic [ADDR_W-1:0]   dest_addr;
        logic [ALPHA_W-1:0]  alpha;
        logic [SIZE_W-1:0]   xfer_width;
        logic [SIZE_W-1:0]   xfer_height;
    } res_t;

endpackage

// ----- hdl/rsz_ifs.sv -----
// Request, result and configuration channel interfaces.
interface rsz_in_if import rsz_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] work_addr;

    modport source (output valid, output req_type, output work_addr, input ready);
    modport sink   (input valid, input req_type, input work_addr, output ready);
endinterface

interface rsz_out_if import rsz_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic               pass;
    logic [ADDR_W-1:0]  bg_addr;
    logic [ADDR_W-1:0]  fg_addr;
    logic [ADDR_W-1:0]  dest_addr;
    logic [ALPHA_W-1:0] alpha;
    logic [SIZE_W-1:0]  xfer_width;
    logic [SIZE_W-1:0]  xfer_height;

    modport source (output valid, output kind, output pass, output bg_addr, output fg_addr,
                    output dest_addr, output alpha, output xfer_width, output xfer_height,
                    input ready);
    modport sink   (input valid, input kind, input pass, input bg_addr, input fg_addr,
                    input dest_addr, input alpha, input xfer_width, input xfer_height,
                    output ready);
endinterface

interface rsz_cfg_if import rsz_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/rsz_step_div.sv -----
// Bit-serial restoring divider: ((size-1) << FRAC_BITS) / max(out_size,1).
module rsz_step_div
    import rsz_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SIZE_W-1:0] size,
    input  logic [SIZE_W-1:0] out_size,
    output logic              done,
    output logic [ADDR_W-1:0] quotient
);

    localparam int NUM_W = SIZE_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] div_reg;
    logic [NUM_W-1:0]  quo_reg;

    logic [SIZE_W-1:0] size_m1;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W-1:0] diff;
    logic              ge;

    // size of zero saturates to zero, divisor of zero counts as one
    assign size_m1 = (size == '0) ? '0 : size - SIZE_W'(1);
    assign trial   = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = trial[SIZE_W-1:0] - div_reg;
    assign ge      = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (count_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= {size_m1, {FRAC_BITS{1'b0}}};
            div_reg <= (out_size == '0) ? SIZE_W'(1) : out_size;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff : trial[SIZE_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = ADDR_W'(quo_reg);

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> count_reg != '0)
        else $error("divider busy with no bits left");

endmodule

// ----- hdl/two_pass_resize_line_sequencer_unit.sv -----
// Top level: two-pass separable linear resize sequencer driving a blend engine.
// Start: two step divisions in the bit-serial step divider (rows, then columns, one after
//   the other), then the line*pitch multiply, address add and output load.
// Transfer complete: state update, line*pitch multiply, address add, output load.
// Busy start, done, error: output load only; ignored requests: no result. Output register frees input.
// Reset (rst_n, async, active low): idle, registers at their defaults, no result pending.
module two_pass_resize_line_sequencer_unit
    import rsz_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    rsz_in_if.sink    cmd,
    rsz_out_if.source res,
    rsz_cfg_if.sink   cfg
);

    localparam int LINE_W = ADDR_W - FRAC_BITS;
    localparam int PROD_W = LINE_W + PITCH_W;

    // sequencer state
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_ROW,
        S_DIV_COL,
        S_MUL,
        S_ADD,
        S_EMIT
    } seq_state_t;

    // resize pass
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_ROW  = 2'd1,
        ST_COL  = 2'd2
    } stage_t;

    // configuration registers
    logic [ADDR_W-1:0]  src_start_reg;
    logic [PITCH_W-1:0] src_pitch_reg;
    logic [SIZE_W-1:0]  src_width_reg;
    logic [SIZE_W-1:0]  src_height_reg;
    logic [ADDR_W-1:0]  out_start_reg;
    logic [PIX_W-1:0]   out_pix_reg;
    logic [SIZE_W-1:0]  out_width_reg;
    logic [SIZE_W-1:0]  out_height_reg;

    // resize state
    seq_state_t         state_reg;
    stage_t             stage_reg;
    logic [SIZE_W-1:0]  remaining_reg;
    logic [ADDR_W-1:0]  blend_index_reg;
    logic [ADDR_W-1:0]  row_step_reg;
    logic [ADDR_W-1:0]  col_step_reg;
    logic [ADDR_W-1:0]  dest_cursor_reg;
    logic [ADDR_W-1:0]  work_base_reg;

    // datapath
    logic [ADDR_W-1:0]  prod_reg;
    res_t               pend_reg;
    res_t               out_reg;
    logic               out_valid_reg;
    res_t               status_res;

    logic               cmd_fire;
    logic               div_start;
    logic               div_done;
    logic [ADDR_W-1:0]  div_quot;
    logic [SIZE_W-1:0]  div_size;
    logic [SIZE_W-1:0]  div_out_size;

    logic [LINE_W-1:0]  line;
    logic [PITCH_W-1:0] pitch_sel;
    logic [PROD_W-1:0]  prod_full;
    logic [ADDR_W-1:0]  base_sel;
    logic [ADDR_W-1:0]  bg_sum;
    logic [ADDR_W-1:0]  dest_step;
    logic [SIZE_W-1:0]  remaining_dec;
    logic               out_free;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || res.ready;

    // Both steps share one divider: rows first (started from idle), columns right after.
    assign div_start = (cmd_fire && cmd.req_type == REQ_START && stage_reg == ST_IDLE)
                     || (state_reg == S_DIV_ROW && div_done);
    assign div_size     = (state_reg == S_IDLE) ? src_height_reg : src_width_reg;
    assign div_out_size = (state_reg == S_IDLE) ? out_height_reg : out_width_reg;

    rsz_step_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .size     (div_size),
        .out_size (div_out_size),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Line address: base + line*pitch. Row pass reads source rows, column pass
    // reads 4-byte work-buffer columns.
    assign line      = blend_index_reg[ADDR_W-1:FRAC_BITS];
    assign pitch_sel = (stage_reg == ST_ROW) ? src_pitch_reg : PITCH_W'(WORK_PIX_BYTES);
    assign prod_full = line * pitch_sel;
    assign base_sel  = (stage_reg == ST_ROW) ? src_start_reg : work_base_reg;
    assign bg_sum    = base_sel + prod_reg;

    // Row pass steps one work-buffer line (width*4 bytes), column pass one output pixel.
    assign dest_step = (stage_reg == ST_ROW) ? ADDR_W'({src_width_reg, 2'b00})
                                             : ADDR_W'(out_pix_reg);
    assign remaining_dec = remaining_reg - SIZE_W'(1);

    // status result for a request taken while idle; a blend command replaces it in S_ADD
    always_comb
    begin
        status_res = '0;
        if (cmd.req_type == REQ_START)
        begin
            status_res.kind = KIND_BUSY;
        end
        else if (cmd.req_type == REQ_ERROR)
        begin
            status_res.kind = KIND_ERROR;
            status_res.pass = (stage_reg == ST_COL);
        end
        else
        begin
            status_res.kind = KIND_DONE;
            status_res.pass = (stage_reg == ST_COL);
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_start_reg  <= '0;
            src_pitch_reg  <= '0;
            src_width_reg  <= SIZE_W'(1);
            src_height_reg <= SIZE_W'(1);
            out_start_reg  <= '0;
            out_pix_reg    <= PIX_W'(WORK_PIX_BYTES);
            out_width_reg  <= SIZE_W'(1);
            out_height_reg <= SIZE_W'(1);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_SRC_START:  src_start_reg  <= cfg.data[ADDR_W-1:0];
                REG_SRC_PITCH:  src_pitch_reg  <= cfg.data[PITCH_W-1:0];
                REG_SRC_WIDTH:  src_width_reg  <= cfg.data[SIZE_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg.data[SIZE_W-1:0];
                REG_OUT_START:  out_start_reg  <= cfg.data[ADDR_W-1:0];
                REG_OUT_PIX:    out_pix_reg    <= cfg.data[PIX_W-1:0];
                REG_OUT_WIDTH:  out_width_reg  <= cfg.data[SIZE_W-1:0];
                REG_OUT_HEIGHT: out_height_reg <= cfg.data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and resize state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            stage_reg       <= ST_IDLE;
            remaining_reg   <= '0;
            blend_index_reg <= '0;
            row_step_reg    <= '0;
            col_step_reg    <= '0;
            dest_cursor_reg <= '0;
            work_base_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // load wins over a taken result: the register is free in that case
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.valid && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        case (cmd.req_type)
                            REQ_START:
                            begin
                                if (stage_reg != ST_IDLE)
                                begin
                                    state_reg <= S_EMIT;  // rejected, state kept
                                end
                                else
                                begin
                                    dest_cursor_reg <= cmd.work_addr;
                                    work_base_reg   <= cmd.work_addr;
                                    state_reg       <= S_DIV_ROW;
                                end
                            end
                            REQ_COMPLETE:
                            begin
                                if (stage_reg != ST_IDLE)
                                begin
                                    if (remaining_dec != '0)
                                    begin
                                        remaining_reg   <= remaining_dec;
                                        dest_cursor_reg <= dest_cursor_reg + dest_step;
                                        blend_index_reg <= blend_index_reg +
                                            ((stage_reg == ST_ROW) ? row_step_reg
                                                                   : col_step_reg);
                                        state_reg <= S_MUL;
                                    end
                                    else if (stage_reg == ST_ROW)
                                    begin
                                        // row pass finished, columns start at half a step
                                        stage_reg       <= ST_COL;
                                        remaining_reg   <= (out_width_reg == '0) ?
                                                           SIZE_W'(1) : out_width_reg;
                                        blend_index_reg <= {1'b0, col_step_reg[ADDR_W-1:1]};
                                        dest_cursor_reg <= out_start_reg;
                                        state_reg       <= S_MUL;
                                    end
                                    else
                                    begin
                                        remaining_reg <= remaining_dec;
                                        stage_reg     <= ST_IDLE;
                                        state_reg     <= S_EMIT;
                                    end
                                end
                            end
                            REQ_ERROR:
                            begin
                                if (stage_reg != ST_IDLE)
                                begin
                                    stage_reg <= ST_IDLE;
                                    state_reg <= S_EMIT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV_ROW:
                begin
                    if (div_done)
                    begin
                        row_step_reg <= div_quot;
                        state_reg    <= S_DIV_COL;
                    end
                end
                S_DIV_COL:
                begin
                    if (div_done)
                    begin
                        col_step_reg    <= div_quot;
                        blend_index_reg <= {1'b0, row_step_reg[ADDR_W-1:1]};
                        remaining_reg   <= (out_height_reg == '0) ?
                                           SIZE_W'(1) : out_height_reg;
                        stage_reg       <= ST_ROW;
                        state_reg       <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    // hold the pending result until the output register is free
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                pend_reg <= status_res;
            end
            S_MUL:
            begin
                prod_reg <= ADDR_W'(prod_full);
            end
            S_ADD:
            begin
                pend_reg.kind      <= KIND_BLEND;
                pend_reg.pass      <= (stage_reg == ST_COL);
                pend_reg.bg_addr   <= bg_sum;
                pend_reg.fg_addr   <= bg_sum + ADDR_W'(pitch_sel);
                pend_reg.dest_addr <= dest_cursor_reg;
                pend_reg.alpha     <= blend_index_reg[FRAC_BITS-1 -: ALPHA_W];
                if (stage_reg == ST_ROW)
                begin
                    pend_reg.xfer_width  <= src_width_reg;
                    pend_reg.xfer_height <= SIZE_W'(1);
                end
                else
                begin
                    pend_reg.xfer_width  <= SIZE_W'(1);
                    pend_reg.xfer_height <= out_height_reg;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_reg <= pend_reg;
                end
            end
            default: ;
        endcase
    end

    assign res.valid       = out_valid_reg;
    assign res.kind        = out_reg.kind;
    assign res.pass        = out_reg.pass;
    assign res.bg_addr     = out_reg.bg_addr;
    assign res.fg_addr     = out_reg.fg_addr;
    assign res.dest_addr   = out_reg.dest_addr;
    assign res.alpha       = out_reg.alpha;
    assign res.xfer_width  = out_reg.xfer_width;
    assign res.xfer_height = out_reg.xfer_height;

    a_pass_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg != ST_IDLE |-> remaining_reg != '0)
        else $error("active pass with zero lines remaining");

    a_blend_needs_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_ADD) |-> stage_reg != ST_IDLE)
        else $error("blend command built while idle");

    a_div_only_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_ROW || state_reg == S_DIV_COL) |-> stage_reg == ST_IDLE)
        else $error("step division while a pass is active");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_ROW || state_reg == S_DIV_COL))
        else $error("divider finished outside a division state");

endmodule
